// ===== src/sipq_pkg.sv =====
// Shared types and codes for the sorted-insert priority queue.
package sipq_pkg;

    // Operation codes carried on the opcode port.
    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    // Status codes returned with every result word.
    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_FULL  = 2'd2;

    // Width of the entry_count port.
    localparam int COUNT_PORT_BITS = 6;

    // Non-key part of a stored record.
    typedef struct packed {
        logic [7:0]  pickup;
        logic [7:0]  dropoff;
        logic [7:0]  kind;
        logic [15:0] expiry;
    } payload_t;

    // Per-cycle command broadcast to every cell of the row.
    typedef struct packed {
        logic insert;
        logic remove;
    } cell_ctrl_t;

endpackage

// ===== src/sipq_cell.sv =====
// One slot of the sorted row: holds a record and shifts it left or right.
module sipq_cell #(
    parameter int KEY_BITS = 16
) (
    input  logic                  clk,
    input  sipq_pkg::cell_ctrl_t  ctrl,
    input  logic                  occupied,
    input  logic [KEY_BITS-1:0]   new_key,
    input  sipq_pkg::payload_t    new_data,
    input  logic                  left_greater,
    input  logic [KEY_BITS-1:0]   left_key,
    input  sipq_pkg::payload_t    left_data,
    input  logic [KEY_BITS-1:0]   right_key,
    input  sipq_pkg::payload_t    right_data,
    output logic                  greater,
    output logic [KEY_BITS-1:0]   key,
    output sipq_pkg::payload_t    data
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    sipq_pkg::payload_t  data_reg;
    sipq_pkg::payload_t  data_next;

    // An empty slot behaves as if it held an infinitely large key.
    assign greater = !occupied || (key_reg > new_key);

    // Insert: shift right past the insertion point, take the new record there.
    // Remove: every slot takes its right neighbor's record.
    always_comb
    begin
        key_next  = key_reg;
        data_next = data_reg;
        if (ctrl.insert)
        begin
            if (left_greater)
            begin
                key_next  = left_key;
                data_next = left_data;
            end
            else if (greater)
            begin
                key_next  = new_key;
                data_next = new_data;
            end
        end
        else if (ctrl.remove)
        begin
            key_next  = right_key;
            data_next = right_data;
        end
    end

    // Record storage needs no reset; occupancy comes from the count.
    always_ff @(posedge clk)
    begin
        key_reg  <= key_next;
        data_reg <= data_next;
    end

    assign key  = key_reg;
    assign data = data_reg;

endmodule

// ===== src/sorted_insert_priority_queue_core.sv =====
// Top level of the sorted-insert priority queue built as a row of shift cells.
//
//   channel | direction | handshake            | words
//   input   | in        | in_valid / in_ready   | opcode, arrival_time, places, kind, expiry
//   output  | out       | out_valid / out_ready | status, record fields, entry_count
//
// All cells compare against the new key and shift in the same edge, so a word
// can be accepted on every cycle while the output register can take its result.
// The result word sits in an output register; a new word is taken whenever
// that register is empty or being drained in the same cycle.
// Reset clears the record count and the output valid flag; records are not cleared.
module sorted_insert_priority_queue_core #(
    parameter int QUEUE_DEPTH = 32,
    parameter int KEY_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        opcode,
    input  logic [15:0] arrival_time,
    input  logic [7:0]  pickup_place,
    input  logic [7:0]  dropoff_place,
    input  logic [7:0]  item_kind,
    input  logic [15:0] expiry_time,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  status,
    output logic [15:0] out_arrival_time,
    output logic [7:0]  out_pickup,
    output logic [7:0]  out_dropoff,
    output logic [7:0]  out_item_kind,
    output logic [15:0] out_expiry,
    output logic [5:0]  entry_count
);

    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 out_valid_reg;
    logic [1:0]           status_reg;
    logic [15:0]          arrival_reg;
    sipq_pkg::payload_t   out_data_reg;
    logic [5:0]           entry_count_reg;

    logic                 fire;
    logic                 is_deq;
    logic                 full;
    logic                 empty;
    sipq_pkg::cell_ctrl_t ctrl;
    logic [KEY_BITS-1:0]  new_key;
    sipq_pkg::payload_t   new_data;

    logic [KEY_BITS-1:0]  cell_key     [QUEUE_DEPTH];
    sipq_pkg::payload_t   cell_data    [QUEUE_DEPTH];
    logic                 cell_greater [QUEUE_DEPTH];

    // Handshake and operation decode.
    assign in_ready = !out_valid_reg || out_ready;
    assign fire     = in_valid && in_ready;
    assign is_deq   = (opcode == sipq_pkg::OP_DEQUEUE);
    assign full     = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.insert = fire && !is_deq && !full;
    assign ctrl.remove = fire && is_deq && !empty;

    assign new_key          = KEY_BITS'(arrival_time);
    assign new_data.pickup  = pickup_place;
    assign new_data.dropoff = dropoff_place;
    assign new_data.kind    = item_kind;
    assign new_data.expiry  = expiry_time;

    // The row of cells, slot 0 holding the head.
    for (genvar i = 0; i < QUEUE_DEPTH; i++)
    begin : g_cell
        logic                left_greater;
        logic [KEY_BITS-1:0] left_key;
        sipq_pkg::payload_t  left_data;
        logic [KEY_BITS-1:0] right_key;
        sipq_pkg::payload_t  right_data;

        if (i == 0)
        begin : g_first
            assign left_greater = 1'b0;
            assign left_key     = new_key;
            assign left_data    = new_data;
        end
        else
        begin : g_inner_left
            assign left_greater = cell_greater[i-1];
            assign left_key     = cell_key[i-1];
            assign left_data    = cell_data[i-1];
        end

        if (i == QUEUE_DEPTH - 1)
        begin : g_last
            assign right_key  = cell_key[i];
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_key  = cell_key[i+1];
            assign right_data = cell_data[i+1];
        end

        sipq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk          (clk),
            .ctrl         (ctrl),
            .occupied     (CNT_W'(i) < count_reg),
            .new_key      (new_key),
            .new_data     (new_data),
            .left_greater (left_greater),
            .left_key     (left_key),
            .left_data    (left_data),
            .right_key    (right_key),
            .right_data   (right_data),
            .greater      (cell_greater[i]),
            .key          (cell_key[i]),
            .data         (cell_data[i])
        );
    end

    // Record count.
    always_comb
    begin
        count_next = count_reg;
        if (ctrl.insert)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (ctrl.remove)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result word register.
    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            entry_count_reg <= sipq_pkg::COUNT_PORT_BITS'(count_next);
            if (ctrl.remove)
            begin
                status_reg   <= sipq_pkg::STATUS_OK;
                arrival_reg  <= 16'(cell_key[0]);
                out_data_reg <= cell_data[0];
            end
            else
            begin
                if (is_deq)
                begin
                    status_reg <= sipq_pkg::STATUS_EMPTY;
                end
                else if (full)
                begin
                    status_reg <= sipq_pkg::STATUS_FULL;
                end
                else
                begin
                    status_reg <= sipq_pkg::STATUS_OK;
                end
                arrival_reg  <= '0;
                out_data_reg <= '0;
            end
        end
    end

    assign out_valid        = out_valid_reg;
    assign status           = status_reg;
    assign out_arrival_time = arrival_reg;
    assign out_pickup       = out_data_reg.pickup;
    assign out_dropoff      = out_data_reg.dropoff;
    assign out_item_kind    = out_data_reg.kind;
    assign out_expiry       = out_data_reg.expiry;
    assign entry_count      = entry_count_reg;

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("record count exceeds queue depth");

    // A refused enqueue leaves the count alone.
    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        fire && !is_deq && full |=> count_reg == $past(count_reg))
        else $error("enqueue on full queue changed the count");

    // A successful dequeue lowers the count by one and reports ok.
    a_deq_count: assert property (@(posedge clk) disable iff (!rst_n)
        fire && is_deq && !empty |=>
            count_reg == $past(count_reg) - 1'b1 && status_reg == sipq_pkg::STATUS_OK)
        else $error("dequeue did not remove exactly one record");

    // An empty-queue report always comes with a zero count.
    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && status_reg == sipq_pkg::STATUS_EMPTY |-> entry_count_reg == '0)
        else $error("empty status with nonzero count");

endmodule
